@@ src/imu_frame_deframer_macros.svh @@
// Assertion macros used by the deframer checker.
`ifndef IMU_FRAME_DEFRAMER_MACROS_SVH
`define IMU_FRAME_DEFRAMER_MACROS_SVH

// Concurrent assertion on a full property, sampled on clk, off during reset.
`define IMUFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Concurrent assertion of an overlapping implication.
`define IMUFD_ASSERT_IMP(label, ante, cons, msg) \
	`IMUFD_ASSERT(label, (ante) |-> (cons), msg)

`endif

@@ src/imufd_pkg.sv @@
`default_nettype none
package imufd_pkg;

	// Default frame length in bytes, header included.
	localparam int FRAME_BYTES_DEF = 24;

	// Header bytes 'K' and 'S'.
	localparam logic [7:0] HDR_FIRST  = 8'h4B;
	localparam logic [7:0] HDR_SECOND = 8'h53;

	// Frame offset of the first payload byte and the byte after the last field.
	localparam int FIELD_FIRST_BYTE = 4;
	localparam int FIELD_END_BYTE   = 22 + 2;
	localparam int FIELD_COUNT      = 10;
	localparam int FIELD_IDX_W      = 4;

	// Offset at which collection resumes after the header pair.
	localparam int AFTER_HEADER = 2;

	// One queued operation for the field assembler.
	typedef struct packed {
		logic                   wr_low;
		logic                   wr_high;
		logic                   last;
		logic [FIELD_IDX_W-1:0] idx;
		logic [7:0]             data;
	} op_t;

	// Ten assembled 16-bit fields of one frame.
	typedef logic [FIELD_COUNT-1:0][15:0] fields_t;

endpackage
`default_nettype wire

@@ src/imufd_front.sv @@
`default_nettype none
module imufd_front import imufd_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       chunk_start,
	output logic            push,
	output op_t             push_op,
	input  wire logic       q_ready
);

	localparam int POS_W = $clog2(FRAME_BYTES);

	logic             collecting_q;
	logic             pair_second_q;
	logic             first_was_k_q;
	logic [POS_W-1:0] pos_q;

	logic             accept;
	logic             coll_eff;
	logic             ps_eff;
	logic             fwk_eff;
	logic             in_fields;
	logic             is_last;
	logic [POS_W-1:0] rel;

	assign in_ready = q_ready;
	assign accept   = in_valid && q_ready;

	// A chunk start restarts the hunt before this word is classified.
	assign coll_eff = collecting_q && !chunk_start;
	assign ps_eff   = pair_second_q && !chunk_start;
	assign fwk_eff  = first_was_k_q && !chunk_start;

	// Classify a collected word by its offset in the frame.
	assign in_fields = (pos_q >= POS_W'(FIELD_FIRST_BYTE)) && (pos_q < POS_W'(FIELD_END_BYTE));
	assign is_last   = (pos_q == POS_W'(FRAME_BYTES - 1));
	assign rel       = pos_q - POS_W'(FIELD_FIRST_BYTE);

	always_comb begin
		push_op.wr_low  = in_fields && !pos_q[0];
		push_op.wr_high = in_fields && pos_q[0];
		push_op.last    = is_last;
		push_op.idx     = rel[FIELD_IDX_W:1];
		push_op.data    = data_byte;
	end

	assign push = accept && coll_eff && (in_fields || is_last);

	// Header hunt on even-aligned pairs, then offset tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q  <= 1'b0;
			pair_second_q <= 1'b0;
			first_was_k_q <= 1'b0;
			pos_q         <= '0;
		end else if (accept) begin
			if (!coll_eff) begin
				if (!ps_eff) begin
					first_was_k_q <= (data_byte == HDR_FIRST);
					pair_second_q <= 1'b1;
					collecting_q  <= 1'b0;
				end else begin
					first_was_k_q <= 1'b0;
					pair_second_q <= 1'b0;
					if (fwk_eff && data_byte == HDR_SECOND) begin
						collecting_q <= 1'b1;
						pos_q        <= POS_W'(AFTER_HEADER);
					end else begin
						collecting_q <= 1'b0;
					end
				end
			end else if (is_last) begin
				collecting_q  <= 1'b0;
				pair_second_q <= 1'b0;
				first_was_k_q <= 1'b0;
				pos_q         <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/imufd_queue.sv @@
`default_nettype none
module imufd_queue import imufd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      q_ready,
	output logic      q_valid,
	output op_t       q_op,
	input  wire logic pop
);

	op_t        entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_ready = (count_q != 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_op    = entry_q[rd_ptr_q];

	// Two-entry circular buffer between the classifier and the assembler.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule
`default_nettype wire

@@ src/imufd_back.sv @@
`default_nettype none
module imufd_back import imufd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  wire op_t  q_op,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output fields_t   out_fields
);

	logic [15:0] field_q [FIELD_COUNT];
	logic [7:0]  low_hold_q;
	logic        out_valid_q;
	fields_t     out_q;
	fields_t     merged;
	logic        out_free;

	// A frame-end word waits until the output register is free.
	assign out_free = !out_valid_q || out_ready;
	assign pop      = q_valid && (!q_op.last || out_free);

	assign out_valid  = out_valid_q;
	assign out_fields = out_q;

	// Field store with the word being written folded in.
	always_comb begin
		for (int i = 0; i < FIELD_COUNT; i++) begin
			if (q_op.wr_high && q_op.idx == FIELD_IDX_W'(i)) begin
				merged[i] = {q_op.data, low_hold_q};
			end else begin
				merged[i] = field_q[i];
			end
		end
	end

	// Low byte hold and field store, written as words are popped.
	always_ff @(posedge clk) begin
		if (pop && q_op.wr_low) begin
			low_hold_q <= q_op.data;
		end
		if (pop && q_op.wr_high) begin
			field_q[q_op.idx] <= {q_op.data, low_hold_q};
		end
		if (pop && q_op.last) begin
			out_q <= merged;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && q_op.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ src/imu_frame_deframer.sv @@
// IMU frame deframer: takes one byte word per cycle when ready, hunts for the 'K','S'
// header on even-aligned byte pairs, collects a FRAME_BYTES long frame and emits the ten
// little-endian fields of each completed frame as one output word. The frame's last byte
// is registered in the queue and then in the output register. A classifier tracks header
// sync and frame offset, and a two-entry queue passes the payload bytes to a field
// assembler that owns the output register. The block sustains one input word per
// cycle. in_ready drops only while a finished frame is held at the output, the next
// frame's end word waits behind it in the queue, and one payload byte of the frame
// after that has filled the queue. A word with chunk_start set restarts the hunt and
// drops any partial frame.
`default_nettype none
module imu_frame_deframer import imufd_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        chunk_start,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [15:0] gyro_x,
	output logic signed [15:0] gyro_y,
	output logic signed [15:0] gyro_z,
	output logic signed [15:0] accel_x,
	output logic signed [15:0] accel_y,
	output logic signed [15:0] accel_z,
	output logic signed [15:0] magnet_x,
	output logic signed [15:0] magnet_y,
	output logic signed [15:0] magnet_z,
	output logic [15:0]      frame_sequence
);

	logic    push;
	op_t     push_op;
	logic    q_ready;
	logic    q_valid;
	op_t     q_op;
	logic    pop;
	fields_t fields;

	imufd_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.chunk_start(chunk_start),
		.push       (push),
		.push_op    (push_op),
		.q_ready    (q_ready)
	);

	imufd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.q_ready(q_ready),
		.q_valid(q_valid),
		.q_op   (q_op),
		.pop    (pop)
	);

	imufd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_fields(fields)
	);

	// Field order matches the frame layout.
	assign gyro_x         = signed'(fields[0]);
	assign gyro_y         = signed'(fields[1]);
	assign gyro_z         = signed'(fields[2]);
	assign accel_x        = signed'(fields[3]);
	assign accel_y        = signed'(fields[4]);
	assign accel_z        = signed'(fields[5]);
	assign magnet_x       = signed'(fields[6]);
	assign magnet_y       = signed'(fields[7]);
	assign magnet_z       = signed'(fields[8]);
	assign frame_sequence = fields[9];

endmodule
`default_nettype wire

@@ src/imufd_checker.sv @@
`default_nettype none
`include "imu_frame_deframer_macros.svh"
module imufd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] gyro_x,
	input wire logic [15:0] frame_sequence
);

	// A stalled result word holds its value.
	`IMUFD_ASSERT(out_hold_a, out_valid && !out_ready |=> out_valid && $stable(gyro_x), "stalled word changed")
	`IMUFD_ASSERT(seq_hold_a, out_valid && !out_ready |=> $stable(frame_sequence), "stalled sequence changed")

	// Input backpressure only comes from a result held at the output.
	`IMUFD_ASSERT_IMP(ready_low_a, !in_ready, out_valid, "in_ready low without a pending result")

	// A new result never rises straight out of an input stall.
	`IMUFD_ASSERT_IMP(rise_ready_a, $rose(out_valid), $past(in_ready), "result rose under stall")

endmodule

bind imu_frame_deframer imufd_checker u_imufd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.gyro_x        (gyro_x),
	.frame_sequence(frame_sequence)
);
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import imufd_pkg::*;

	localparam int FRAME_LEN       = FRAME_BYTES_DEF;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int STIM_WORDS      = 1100;
	localparam int MIN_FRAMES      = 40;
	localparam int TAIL_CYCLES     = 20;

	// One byte word on the input channel.
	typedef struct {
		logic [7:0] data;
		logic       chunk;
	} in_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic chunk_start = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] gyro_x, gyro_y, gyro_z;
	logic signed [15:0] accel_x, accel_y, accel_z;
	logic signed [15:0] magnet_x, magnet_y, magnet_z;
	logic [15:0] frame_sequence;

	imu_frame_deframer #(.FRAME_BYTES(FRAME_LEN)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.chunk_start(chunk_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gyro_x(gyro_x),
		.gyro_y(gyro_y),
		.gyro_z(gyro_z),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.magnet_x(magnet_x),
		.magnet_y(magnet_y),
		.magnet_z(magnet_z),
		.frame_sequence(frame_sequence)
	);

	in_word_t pending[$];
	fields_t frames_due[$];

	string field_name[FIELD_COUNT] = '{"gyro_x", "gyro_y", "gyro_z", "accel_x", "accel_y",
		"accel_z", "magnet_x", "magnet_y", "magnet_z", "frame_sequence"};

	// Deframer prediction state.
	logic       sync_locked;
	logic       pair_odd;
	logic       lead_was_k;
	logic [7:0] frame_pos;
	logic [7:0] low_hold;
	fields_t    field_acc;

	int words_sent = 0;
	int chunk_words = 0;
	int frames_seen = 0;
	int mismatches = 0;
	int idle_run = 0;
	int calm_left = 0;
	int tx_wait = 0;
	int rx_wait = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Abandon the hunt and any partial frame.
	task automatic drop_frame();
		sync_locked = 1'b0;
		pair_odd    = 1'b0;
		lead_was_k  = 1'b0;
		frame_pos   = 8'd0;
	endtask

	// Advance the predicted deframer by one accepted word.
	task automatic deframe_word(input logic [7:0] b, input logic cs);
		int pos;
		int k;
		if (cs)
			drop_frame();
		if (!sync_locked) begin
			if (!pair_odd) begin
				lead_was_k = (b == HDR_FIRST);
				pair_odd   = 1'b1;
			end else begin
				pair_odd = 1'b0;
				if (lead_was_k && b == HDR_SECOND) begin
					sync_locked = 1'b1;
					frame_pos   = 8'(AFTER_HEADER);
				end
				lead_was_k = 1'b0;
			end
		end else begin
			pos = frame_pos;
			if (pos >= FIELD_FIRST_BYTE && pos < FIELD_END_BYTE) begin
				if (pos % 2 == 0) begin
					low_hold = b;
				end else begin
					k = ((pos - FIELD_FIRST_BYTE) / 2) % FIELD_COUNT;
					field_acc[k] = {b, low_hold};
				end
			end
			pos++;
			if (pos >= FRAME_LEN) begin
				frames_due.push_back(field_acc);
				drop_frame();
			end else begin
				frame_pos = 8'(pos);
			end
		end
	endtask

	// Idle length: none during calm stretches, else mostly none, sometimes short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_left != 0 || r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Random byte with extra weight on the extremes and the header bytes.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
			3: return $urandom_range(0, 1) ? HDR_FIRST : HDR_SECOND;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic queue_word(input logic [7:0] b, input logic cs);
		in_word_t w;
		w.data  = b;
		w.chunk = cs;
		pending.push_back(w);
	endtask

	// Queue the first len bytes of a frame carrying the given fields.
	task automatic queue_frame(input logic lead_cs, input fields_t vals, input int len);
		logic [7:0] b;
		int k;
		for (int i = 0; i < len; i++) begin
			if (i == 0) begin
				b = HDR_FIRST;
			end else if (i == 1) begin
				b = HDR_SECOND;
			end else if (i >= FIELD_FIRST_BYTE && i < FIELD_END_BYTE) begin
				k = (i - FIELD_FIRST_BYTE) / 2;
				b = (i % 2 == 0) ? vals[k][7:0] : vals[k][15:8];
			end else begin
				b = pick_byte();
			end
			queue_word(b, (i == 0) ? lead_cs : 1'b0);
		end
	endtask

	// Calm stretches with no idling on either side.
	always @(posedge clk) begin
		if (calm_left != 0)
			calm_left <= calm_left - 1;
		else if ($urandom_range(0, 299) == 0)
			calm_left <= $urandom_range(100, 400);
	end

	// Input driver: present queued words, with random gaps between them.
	always @(posedge clk) begin : drive_words
		in_word_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				deframe_word(data_byte, chunk_start);
				words_sent++;
				if (chunk_start)
					chunk_words++;
			end
			if (!in_valid || in_ready) begin
				if (tx_wait != 0) begin
					tx_wait <= tx_wait - 1;
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					nxt = pending.pop_front();
					in_valid <= 1'b1;
					data_byte <= nxt.data;
					chunk_start <= nxt.chunk;
					tx_wait <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: compare each accepted frame word with the oldest prediction.
	always @(posedge clk) begin : watch_frames
		fields_t seen;
		fields_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen = {frame_sequence, magnet_z, magnet_y, magnet_x, accel_z, accel_y,
					accel_x, gyro_z, gyro_y, gyro_x};
				if (frames_due.size() == 0) begin
					$error("frame word with no frame pending: sequence %h", frame_sequence);
					mismatches++;
				end else begin
					want = frames_due.pop_front();
					for (int k = 0; k < FIELD_COUNT; k++) begin
						if (seen[k] !== want[k]) begin
							$error("%s: expected %h, got %h", field_name[k], want[k], seen[k]);
							mismatches++;
						end
					end
				end
				frames_seen++;
			end
			if (rx_wait != 0) begin
				rx_wait <= rx_wait - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				rx_wait <= pick_gap();
			end
		end
	end

	// Count cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
	end

	initial begin
		@(posedge arst_n);
		while (idle_run < WATCHDOG_CYCLES)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : run_stimulus
		fields_t vals;
		int frames_built;
		int kind;
		int len;
		logic force_chunk;
		logic lead;

		drop_frame();
		low_hold  = 8'h00;
		field_acc = '0;

		// A 'K' in the second byte of a pair followed by 'S' is not a header.
		queue_word(8'h00, 1'b1);
		queue_word(HDR_FIRST, 1'b0);
		queue_word(HDR_SECOND, 1'b0);
		queue_word(8'hFF, 1'b0);

		// One full frame with the extreme field values.
		vals = {16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000,
			16'hFFFF, 16'h7FFF, 16'h8000};
		queue_frame(1'b1, vals, FRAME_LEN);

		// Random traffic: mostly whole frames, some cut short by a chunk start, some noise.
		frames_built = 1;
		force_chunk  = 1'b0;
		while (pending.size() < STIM_WORDS || frames_built < MIN_FRAMES) begin
			kind = $urandom_range(0, 99);
			for (int k = 0; k < FIELD_COUNT; k++)
				vals[k] = {pick_byte(), pick_byte()};
			if (kind < 75) begin
				lead = force_chunk || ($urandom_range(0, 2) == 0);
				queue_frame(lead, vals, FRAME_LEN);
				frames_built++;
				force_chunk = 1'b0;
			end else if (kind < 87) begin
				len = $urandom_range(1, FRAME_LEN - 1);
				lead = force_chunk || ($urandom_range(0, 1) == 0);
				queue_frame(lead, vals, len);
				force_chunk = 1'b1;
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					lead = (i == 0 && force_chunk) || ($urandom_range(0, 7) == 0);
					queue_word(pick_byte(), lead);
				end
				force_chunk = ($urandom_range(0, 1) == 0);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: every word sent and every predicted frame received.
		do begin
			@(posedge clk);
			#1;
		end while (pending.size() != 0 || in_valid || frames_due.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		#1;
		if (frames_due.size() != 0) begin
			$error("%0d predicted frames never arrived", frames_due.size());
			mismatches++;
		end

		$display("Sent %0d byte words (%0d with chunk start) under random stalls.",
			words_sent, chunk_words);
		$display("Checked %0d decoded frames, %0d field mismatches.", frames_seen, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
